// ===== rtl/tcw_pkg.sv =====
// Package for the text console writer: transfer payload types, action and
// register codes, sequencer states and cell constants.
// Used by text_console_writer_core and the bench; depends on nothing.
`default_nettype none

package tcw_pkg;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic CFG_FOREGROUND = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  localparam int          COLOR_W      = 4;
  localparam logic [7:0]  BLANK_CHAR   = 8'h20;
  localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0]  RESET_ATTR   = 8'h0F;
  localparam logic [3:0]  RESET_FG     = 4'hF;
  localparam logic [3:0]  RESET_BG     = 4'h0;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] character;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT_ADDR,
    S_PUT_WR,
    S_RD_ADDR,
    S_RD_MEM,
    S_SCROLL,
    S_SCROLL_LAST,
    S_BLANK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_writer_core.sv =====
// Text console writer top level: cell store, cursor, sequencer and output register.
// Depends on tcw_pkg and tcw_addr.
//
// A ROWS x COLS store of 16-bit cells (attribute in the high byte) with a cursor.
// After reset the block runs a clearing pass, with in_ready low, that fills the
// store with spaces in attribute 0x0F. A put or read passes an address multiply,
// one store access and the result register, and in_ready returns in the same cycle
// that its result shows. A newline without scroll goes straight to the result
// register. A newline that scrolls, a clear and a put that wraps on the bottom row
// sweep the store one cell a cycle through its single write port. The result
// register lets the next item be accepted while a result still waits on out_ready;
// a second result then holds in_ready low until the first one is taken.
`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [3:0] cfg_wdata
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS + 1);
  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);

  state_t         state_r, state_nxt;
  in_item_t       item_r, item_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic [AW-1:0]  dst_r, dst_nxt;
  logic           cp_vld_r, cp_vld_nxt;
  logic           put_pend_r, put_pend_nxt;
  logic           use_rd_r, use_rd_nxt;
  logic [7:0]     res_char_r, res_char_nxt;
  logic [7:0]     res_color_r, res_color_nxt;
  logic [3:0]     fg_r, bg_r;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;

  logic [15:0]    mem [CELLS];
  logic [15:0]    rdata_r;

  logic [7:0]     attr;
  logic           accept;
  logic           out_load;
  logic           nl_now;
  logic           at_bottom;
  logic           rd_in_range;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [15:0]    wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           addr_en;
  logic [RW-1:0]  addr_row;
  logic [CW-1:0]  addr_col;
  logic [AW-1:0]  addr_r;
  logic [31:0]    row_w, col_w;

  assign attr        = {bg_r, fg_r};
  assign accept      = in_valid && in_ready;
  assign at_bottom   = !(32'(row_r) < ROWS - 1);
  assign nl_now      = (in_data.character == NEWLINE_CHAR) || (32'(col_r) >= COLS);
  assign rd_in_range = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLS);
  assign row_w       = 32'(row_r);
  assign col_w       = 32'(col_r);

  tcw_addr #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_addr (
    .clk    (clk),
    .en     (addr_en),
    .row    (addr_row),
    .col    (addr_col),
    .addr_r (addr_r)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (32'(ptr_r) == CELLS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_PUT: begin
              if (nl_now && at_bottom) begin
                state_nxt = S_SCROLL;
              end else if (in_data.character == NEWLINE_CHAR) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_PUT_ADDR;
              end
            end
            ACT_CLEAR: state_nxt = S_BLANK;
            ACT_READ:  state_nxt = rd_in_range ? S_RD_ADDR : S_RESP;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_PUT_ADDR:    state_nxt = S_PUT_WR;
      S_PUT_WR:      state_nxt = S_RESP;
      S_RD_ADDR:     state_nxt = S_RD_MEM;
      S_RD_MEM:      state_nxt = S_RESP;
      S_SCROLL: begin
        if (32'(ptr_r) == CELLS - 1) begin
          state_nxt = S_SCROLL_LAST;
        end
      end
      S_SCROLL_LAST: state_nxt = S_BLANK;
      S_BLANK: begin
        if (32'(ptr_r) == CELLS - 1) begin
          state_nxt = put_pend_r ? S_PUT_ADDR : S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:       state_nxt = S_INIT;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = ptr_r;
    wr_data  = {attr, BLANK_CHAR};
    rd_en    = 1'b0;
    rd_addr  = addr_r;
    addr_en  = 1'b0;
    addr_row = row_r;
    addr_col = col_r;
    if (cp_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = dst_r;
      wr_data = rdata_r;
    end
    case (state_r)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = {RESET_ATTR, BLANK_CHAR};
      end
      S_IDLE:     in_ready = 1'b1;
      S_PUT_ADDR: addr_en = 1'b1;
      S_PUT_WR: begin
        wr_en   = 1'b1;
        wr_addr = addr_r;
        wr_data = {attr, item_r.character};
      end
      S_RD_ADDR: begin
        addr_en  = 1'b1;
        addr_row = RW'(item_r.read_row);
        addr_col = CW'(item_r.read_col);
      end
      S_RD_MEM:   rd_en = 1'b1;
      S_SCROLL: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r;
      end
      S_BLANK:    wr_en = 1'b1;
      S_RESP:     out_load = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    item_nxt      = item_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ptr_nxt       = ptr_r;
    dst_nxt       = dst_r;
    cp_vld_nxt    = 1'b0;
    put_pend_nxt  = put_pend_r;
    use_rd_nxt    = use_rd_r;
    res_char_nxt  = res_char_r;
    res_color_nxt = res_color_r;
    case (state_r)
      S_INIT: ptr_nxt = AW'(32'(ptr_r) + 1);
      S_IDLE: begin
        if (accept) begin
          item_nxt      = in_data;
          use_rd_nxt    = 1'b0;
          res_char_nxt  = '0;
          res_color_nxt = '0;
          put_pend_nxt  = in_data.character != NEWLINE_CHAR;
          case (in_data.action)
            ACT_PUT: begin
              if (nl_now) begin
                col_nxt = '0;
                if (at_bottom) begin
                  ptr_nxt = AW'(COLS);
                end else begin
                  row_nxt = RW'(32'(row_r) + 1);
                end
              end
            end
            ACT_CLEAR: begin
              row_nxt      = '0;
              col_nxt      = '0;
              ptr_nxt      = '0;
              put_pend_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_PUT_WR: begin
        col_nxt       = CW'(32'(col_r) + 1);
        res_char_nxt  = item_r.character;
        res_color_nxt = attr;
      end
      S_RD_MEM: use_rd_nxt = 1'b1;
      S_SCROLL: begin
        cp_vld_nxt = 1'b1;
        dst_nxt    = AW'(32'(ptr_r) - COLS);
        if (32'(ptr_r) == CELLS - 1) begin
          ptr_nxt = AW'((ROWS - 1) * COLS);
        end else begin
          ptr_nxt = AW'(32'(ptr_r) + 1);
        end
      end
      S_BLANK: ptr_nxt = AW'(32'(ptr_r) + 1);
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt.cursor_row = row_w[4:0];
    out_data_nxt.cursor_col = col_w[6:0];
    out_data_nxt.cell_char  = use_rd_r ? rdata_r[7:0] : res_char_r;
    out_data_nxt.cell_color = use_rd_r ? rdata_r[15:8] : res_color_r;
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      cp_vld_r    <= 1'b0;
      put_pend_r  <= 1'b0;
      use_rd_r    <= 1'b0;
      out_valid_r <= 1'b0;
      fg_r        <= RESET_FG;
      bg_r        <= RESET_BG;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cp_vld_r    <= cp_vld_nxt;
      put_pend_r  <= put_pend_nxt;
      use_rd_r    <= use_rd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FOREGROUND: fg_r <= cfg_wdata[COLOR_W-1:0];
          CFG_BACKGROUND: bg_r <= cfg_wdata[COLOR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    dst_r       <= dst_nxt;
    res_char_r  <= res_char_nxt;
    res_color_r <= res_color_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("store written while idle");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < ROWS) && (32'(col_r) <= COLS))
    else $error("cursor out of range");

  a_copy_dst: assert property (@(posedge clk) disable iff (!rst_n)
    cp_vld_r |-> (32'(dst_r) < CELLS - COLS))
    else $error("scroll copy beyond upper rows");

  a_sweep_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLANK || state_r == S_INIT || state_r == S_SCROLL) |-> (32'(ptr_r) < CELLS))
    else $error("sweep pointer out of store");

  a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result changed");

endmodule

`default_nettype wire

// ===== rtl/tcw_addr.sv =====
// Cell address unit: registered row * COLS + col for the cell store.
// Depends on nothing outside this file.
`default_nettype none

module tcw_addr #(
  parameter int ROWS = 25,
  parameter int COLS = 80,
  localparam int RW = $clog2(ROWS),
  localparam int CW = $clog2(COLS + 1),
  localparam int AW = $clog2(ROWS * COLS)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] row,
  input  logic [CW-1:0] col,
  output logic [AW-1:0] addr_r
);

  logic [AW-1:0] addr_nxt;

  assign addr_nxt = AW'(32'(row) * COLS + 32'(col));

  always_ff @(posedge clk) begin
    if (en) begin
      addr_r <= addr_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Regression bench for text_console_writer_core: a directed table, then random text lines,
// scrolls, clears and cell reads under several color settings and idle patterns.
// Depends on tcw_pkg and the block's RTL; results are checked against a shadow console.
module tb_top
  import tcw_pkg::*;
();

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int CELLS = ROWS * COLS;
  localparam int RANDOM_ITEMS = 1030;
  localparam int PHASES = 5;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int SETTLE_CYCLES = 2100;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic      pinned;
    out_item_t want;
  } pin_t;

  typedef struct packed {
    in_item_t  stim;
    logic      pinned;
    out_item_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_addr = CFG_FOREGROUND;
  logic [3:0] cfg_wdata = '0;

  logic [15:0] shadow_screen [CELLS];
  int          cur_row;
  int          cur_col;
  logic [3:0]  fg_color;
  logic [3:0]  bg_color;

  out_item_t cell_reports_q [$];
  pin_t      pinned_q [$];
  dir_row_t  dir_table [$];
  int        items_sent = 0;
  int        results_seen = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        sender_idle_pct = 0;
  int        recv_stall_pct = 0;

  text_console_writer_core #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] pen_attr();
    return {bg_color, fg_color};
  endfunction

  function automatic void line_feed();
    int i;
    cur_col = 0;
    if (cur_row < ROWS - 1) begin
      cur_row++;
    end else begin
      for (i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = {pen_attr(), BLANK_CHAR};
    end
  endfunction

  function automatic out_item_t console_step(input in_item_t it);
    out_item_t r;
    int i;
    int idx;
    r = '0;
    case (it.action)
      ACT_PUT: begin
        if (it.character == NEWLINE_CHAR) begin
          line_feed();
        end else begin
          if (cur_col >= COLS) line_feed();
          shadow_screen[cur_row * COLS + cur_col] = {pen_attr(), it.character};
          cur_col++;
          r.cell_char = it.character;
          r.cell_color = pen_attr();
        end
      end
      ACT_CLEAR: begin
        for (i = 0; i < CELLS; i++) shadow_screen[i] = {pen_attr(), BLANK_CHAR};
        cur_row = 0;
        cur_col = 0;
      end
      ACT_READ: begin
        if (int'(it.read_row) < ROWS && int'(it.read_col) < COLS) begin
          idx = int'(it.read_row) * COLS + int'(it.read_col);
          r.cell_char = shadow_screen[idx][7:0];
          r.cell_color = shadow_screen[idx][15:8];
        end
      end
      default: ;
    endcase
    r.cursor_row = 5'(cur_row);
    r.cursor_col = 7'(cur_col);
    return r;
  endfunction

  function automatic dir_row_t drow(input logic [1:0] act, input logic [7:0] ch,
                                    input logic [4:0] rr, input logic [6:0] rc,
                                    input logic pinned, input logic [4:0] wr,
                                    input logic [6:0] wc, input logic [7:0] wch,
                                    input logic [7:0] wcol);
    dir_row_t d;
    d.stim = '{action: act, character: ch, read_row: rr, read_col: rc};
    d.pinned = pinned;
    d.want = '{cursor_row: wr, cursor_col: wc, cell_char: wch, cell_color: wcol};
    return d;
  endfunction

  function automatic in_item_t put_item(input logic [7:0] ch);
    in_item_t it;
    it.action = ACT_PUT;
    it.character = ch;
    it.read_row = 5'($urandom_range(0, 31));
    it.read_col = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic in_item_t other_item(input logic [1:0] act);
    in_item_t it;
    it.action = act;
    it.character = 8'($urandom_range(0, 255));
    it.read_row = 5'($urandom_range(0, 31));
    it.read_col = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic in_item_t read_item();
    in_item_t it;
    int pick;
    it = other_item(ACT_READ);
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      it.read_row = 5'(cur_row);
      it.read_col = 7'($urandom_range(0, COLS - 1));
    end else if (pick == 1) begin
      it.read_row = 5'($urandom_range(0, ROWS - 1));
      it.read_col = 7'($urandom_range(0, COLS - 1));
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  task automatic send_item(input in_item_t it, input logic pinned, input out_item_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pinned_q.push_back('{pinned: pinned, want: want});
    in_valid <= 1'b1;
    in_data <= it;
    if (it.action != ACT_SPARE) items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every result is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cell_reports_q.size() != 0) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_FOREGROUND;
    cfg_wdata <= fg;
    @(posedge clk);
    fg_color = fg;
    cfg_addr <= CFG_BACKGROUND;
    cfg_wdata <= bg;
    @(posedge clk);
    bg_color = bg;
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int quota);
    int stop_at;
    int k;
    int n;
    int j;
    logic [7:0] ch;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        n = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 10) : $urandom_range(0, 88);
        if ($urandom_range(0, 7) == 0) n = $urandom_range(COLS - 1, COLS + 1);
        for (j = 0; j < n; j++) begin
          ch = 8'($urandom_range(0, 255));
          if (ch == NEWLINE_CHAR) ch = BLANK_CHAR;
          send_item(put_item(ch), 1'b0, '0);
        end
        if ($urandom_range(0, 9) < 7) send_item(put_item(NEWLINE_CHAR), 1'b0, '0);
      end else if (k < 80) begin
        repeat ($urandom_range(1, 6)) send_item(read_item(), 1'b0, '0);
      end else if (k < 84) begin
        repeat ($urandom_range(1, 26)) send_item(put_item(NEWLINE_CHAR), 1'b0, '0);
      end else if (k < 87) begin
        send_item(other_item(ACT_CLEAR), 1'b0, '0);
      end else if (k < 90) begin
        send_item(other_item(ACT_SPARE), 1'b0, '0);
      end else begin
        send_item(put_item(8'($urandom_range(0, 255))), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    pin_t pin;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (cell_reports_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'(out_data), 32'd0);
      end else begin
        want = cell_reports_q.pop_front();
        if (out_data.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", 32'(out_data.cursor_row), 32'(want.cursor_row));
        if (out_data.cursor_col !== want.cursor_col)
          report_mismatch("cursor_col", 32'(out_data.cursor_col), 32'(want.cursor_col));
        if (out_data.cell_char !== want.cell_char)
          report_mismatch("cell_char", 32'(out_data.cell_char), 32'(want.cell_char));
        if (out_data.cell_color !== want.cell_color)
          report_mismatch("cell_color", 32'(out_data.cell_color), 32'(want.cell_color));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      pin = pinned_q.pop_front();
      want = console_step(in_data);
      if (pin.pinned) want = pin.want;
      cell_reports_q.push_back(want);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_console_writer_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int p;
    for (i = 0; i < CELLS; i++) shadow_screen[i] = {RESET_ATTR, BLANK_CHAR};
    cur_row = 0;
    cur_col = 0;
    fg_color = RESET_FG;
    bg_color = RESET_BG;

    dir_table.push_back(drow(ACT_READ, 8'h00, 5'd0, 7'd0, 1'b1,
                             5'd0, 7'd0, BLANK_CHAR, RESET_ATTR));
    dir_table.push_back(drow(ACT_READ, 8'h00, 5'd24, 7'd79, 1'b1,
                             5'd0, 7'd0, BLANK_CHAR, RESET_ATTR));
    dir_table.push_back(drow(ACT_READ, 8'h00, 5'd25, 7'd0, 1'b1, 5'd0, 7'd0, 8'h00, 8'h00));
    dir_table.push_back(drow(ACT_READ, 8'h00, 5'd0, 7'd80, 1'b1, 5'd0, 7'd0, 8'h00, 8'h00));
    dir_table.push_back(drow(ACT_READ, 8'hFF, 5'd31, 7'd127, 1'b1, 5'd0, 7'd0, 8'h00, 8'h00));
    dir_table.push_back(drow(ACT_SPARE, 8'hFF, 5'd31, 7'd127, 1'b1, 5'd0, 7'd0, 8'h00, 8'h00));
    dir_table.push_back(drow(ACT_PUT, 8'h00, 5'd0, 7'd0, 1'b1, 5'd0, 7'd1, 8'h00, RESET_ATTR));
    dir_table.push_back(drow(ACT_PUT, 8'hFF, 5'd31, 7'd127, 1'b1,
                             5'd0, 7'd2, 8'hFF, RESET_ATTR));
    dir_table.push_back(drow(ACT_READ, 8'h00, 5'd0, 7'd1, 1'b1, 5'd0, 7'd2, 8'hFF, RESET_ATTR));
    dir_table.push_back(drow(ACT_PUT, NEWLINE_CHAR, 5'd0, 7'd0, 1'b1,
                             5'd1, 7'd0, 8'h00, 8'h00));
    dir_table.push_back(drow(ACT_PUT, 8'h0B, 5'd0, 7'd0, 1'b1, 5'd1, 7'd1, 8'h0B, RESET_ATTR));
    dir_table.push_back(drow(ACT_PUT, 8'h09, 5'd0, 7'd0, 1'b1, 5'd1, 7'd2, 8'h09, RESET_ATTR));
    dir_table.push_back(drow(ACT_PUT, NEWLINE_CHAR, 5'd0, 7'd0, 1'b1,
                             5'd2, 7'd0, 8'h00, 8'h00));
    dir_table.push_back(drow(ACT_PUT, NEWLINE_CHAR, 5'd0, 7'd0, 1'b1,
                             5'd3, 7'd0, 8'h00, 8'h00));
    dir_table.push_back(drow(ACT_READ, 8'h00, 5'd1, 7'd0, 1'b1, 5'd3, 7'd0, 8'h0B, RESET_ATTR));
    dir_table.push_back(drow(ACT_CLEAR, 8'hFF, 5'd31, 7'd127, 1'b1,
                             5'd0, 7'd0, 8'h00, 8'h00));
    dir_table.push_back(drow(ACT_READ, 8'h00, 5'd1, 7'd0, 1'b1,
                             5'd0, 7'd0, BLANK_CHAR, RESET_ATTR));
    dir_table.push_back(drow(ACT_READ, 8'h00, 5'd24, 7'd0, 1'b1,
                             5'd0, 7'd0, BLANK_CHAR, RESET_ATTR));
    dir_table.push_back(drow(ACT_PUT, 8'h41, 5'd0, 7'd0, 1'b0, '0, '0, '0, '0));
    dir_table.push_back(drow(ACT_PUT, 8'h7F, 5'd0, 7'd0, 1'b0, '0, '0, '0, '0));
    dir_table.push_back(drow(ACT_READ, 8'h00, 5'd0, 7'd0, 1'b0, '0, '0, '0, '0));
    dir_table.push_back(drow(ACT_SPARE, 8'h00, 5'd0, 7'd0, 1'b0, '0, '0, '0, '0));
    dir_table.push_back(drow(ACT_PUT, NEWLINE_CHAR, 5'd0, 7'd0, 1'b0, '0, '0, '0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < dir_table.size(); i++)
      send_item(dir_table[i].stim, dir_table[i].pinned, dir_table[i].want);

    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          set_colors(4'hF, 4'h0);
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          set_colors(4'h0, 4'h0);
          sender_idle_pct = 52;
          recv_stall_pct = 0;
        end
        2: begin
          set_colors(4'hF, 4'hF);
          sender_idle_pct = 0;
          recv_stall_pct = 52;
        end
        3: begin
          set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
          sender_idle_pct = 7;
          recv_stall_pct = 7;
        end
        default: begin
          set_colors(4'h0, 4'hF);
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      run_random(RANDOM_ITEMS / PHASES);
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (cell_reports_q.size() != 0)
      report_mismatch("results never delivered", 32'(cell_reports_q.size()), 32'd0);
    if (mismatch_count == 0) begin
      $display("text_console_writer_core regression: pass");
    end else begin
      $display("text_console_writer_core regression: fail");
    end
    $finish;
  end

endmodule
